// ===== rtl/core/ual_pkg.sv =====
// shared types, codes and defaults for the unordered array list engine
// no dependencies; imported by ual_ctrl, ual_dp and the top level
package ual_pkg;

  localparam int CAPACITY_DEF = 256;

  // command codes
  localparam logic [2:0] CMD_APPEND    = 3'd0;
  localparam logic [2:0] CMD_INSERT_AT = 3'd1;
  localparam logic [2:0] CMD_POP_LAST  = 3'd2;
  localparam logic [2:0] CMD_DEL_VALUE = 3'd3;
  localparam logic [2:0] CMD_DEL_AT    = 3'd4;
  localparam logic [2:0] CMD_SEARCH    = 3'd5;
  localparam logic [2:0] CMD_CLEAR     = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // read address select
  localparam logic [1:0] RD_POS  = 2'd0;
  localparam logic [1:0] RD_LAST = 2'd1;
  localparam logic [1:0] RD_SCAN = 2'd2;

  // write address select
  localparam logic [1:0] WR_COUNT = 2'd0;
  localparam logic [1:0] WR_POS   = 2'd1;
  localparam logic [1:0] WR_HOLD  = 2'd2;

  // write data select
  localparam logic WD_VAL = 1'b0;
  localparam logic WD_RD  = 1'b1;

  // found position select for the result
  localparam logic [1:0] FND_ZERO = 2'd0;
  localparam logic [1:0] FND_CMP  = 2'd1;
  localparam logic [1:0] FND_HOLD = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic [7:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         found_position;
    logic signed [31:0] popped_value;
    logic [8:0]         entry_count;
  } out_item_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       empty;
    logic       pos_gt_count;
    logic       pos_ge_count;
    logic       scan_more;
    logic       cmp_valid;
    logic       match;
    logic       out_free;
  } dp_status_t;

  typedef struct packed {
    logic       load_item;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       wd_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       scan_start;
    logic       scan_step;
    logic       hold_load;
    logic       res_set;
    logic [1:0] res_status;
    logic [1:0] res_fnd_sel;
    logic       res_pop;
    logic       out_load;
  } dp_ctrl_t;

endpackage

// ===== rtl/core/ual_dp.sv =====
// datapath: entry memory, count, scan counters, result and output registers
// depends on ual_pkg; driven by ual_ctrl
module ual_dp #(
  parameter int CAPACITY = ual_pkg::CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ual_pkg::in_item_t    in_item,
  input  ual_pkg::dp_ctrl_t    ctl,
  output ual_pkg::dp_status_t  sts,
  input  logic                 out_stall,
  output logic                 out_valid,
  output ual_pkg::out_item_t   out_item
);
  import ual_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > 8) ? CW : 8;
  localparam int FW = (AW > 8) ? AW : 8;
  localparam int NW = (CW > 9) ? CW : 9;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [31:0]        mem [CAPACITY];
  logic [31:0]        rd_data;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;

  logic [2:0]         cmd;
  logic [7:0]         pos;
  logic [31:0]        val;
  logic [CW-1:0]      count;
  logic [CW-1:0]      last;
  logic [EW-1:0]      pos_e;
  logic [EW-1:0]      cnt_e;

  logic [CW-1:0]      scan_addr;
  logic [AW-1:0]      cmp_idx;
  logic               cmp_valid;
  logic [AW-1:0]      hold_idx;

  logic [1:0]         res_status;
  logic [7:0]         res_found;
  logic [31:0]        res_popped;
  logic [AW-1:0]      fnd_sel;
  logic [FW-1:0]      fnd_ext;
  logic [NW-1:0]      cnt_ext;

  assign last  = count - CW'(1);
  assign pos_e = EW'(pos);
  assign cnt_e = EW'(count);

  always_comb begin
    unique case (ctl.rd_sel)
      RD_POS:  rd_addr = pos_e[AW-1:0];
      RD_LAST: rd_addr = last[AW-1:0];
      RD_SCAN: rd_addr = scan_addr[AW-1:0];
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.wr_sel)
      WR_COUNT: wr_addr = count[AW-1:0];
      WR_POS:   wr_addr = pos_e[AW-1:0];
      WR_HOLD:  wr_addr = hold_idx;
      default:  wr_addr = '0;
    endcase
  end

  assign wr_data = (ctl.wd_sel == WD_RD) ? rd_data : val;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd <= in_item.command;
      pos <= in_item.position;
      val <= in_item.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.cnt_clr) begin
      count <= '0;
    end else if (ctl.cnt_inc) begin
      count <= count + CW'(1);
    end else if (ctl.cnt_dec) begin
      count <= last;
    end
  end

  // scan pipeline: cmp_idx tags the entry now sitting in rd_data
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      scan_addr <= '0;
    end else if (ctl.scan_start) begin
      cmp_valid <= 1'b0;
      scan_addr <= '0;
    end else if (ctl.scan_step) begin
      cmp_valid <= sts.scan_more;
      if (sts.scan_more) begin
        scan_addr <= scan_addr + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_step) begin
      cmp_idx <= scan_addr[AW-1:0];
    end
    if (ctl.hold_load) begin
      hold_idx <= cmp_idx;
    end
  end

  always_comb begin
    unique case (ctl.res_fnd_sel)
      FND_CMP:  fnd_sel = cmp_idx;
      FND_HOLD: fnd_sel = hold_idx;
      default:  fnd_sel = '0;
    endcase
  end

  assign fnd_ext = FW'(fnd_sel);
  assign cnt_ext = NW'(count);

  always_ff @(posedge clk) begin
    if (ctl.res_set) begin
      res_status <= ctl.res_status;
      res_found  <= fnd_ext[7:0];
      res_popped <= ctl.res_pop ? rd_data : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_item.status         <= res_status;
      out_item.found_position <= res_found;
      out_item.popped_value   <= res_popped;
      out_item.entry_count    <= cnt_ext[8:0];
    end
  end

  always_comb begin
    sts.cmd          = cmd;
    sts.full         = (count == CAP_C);
    sts.empty        = (count == '0);
    sts.pos_gt_count = (pos_e > cnt_e);
    sts.pos_ge_count = (pos_e >= cnt_e);
    sts.scan_more    = (scan_addr < count);
    sts.cmp_valid    = cmp_valid;
    sts.match        = cmp_valid && (rd_data == val);
    sts.out_free     = !out_valid || !out_stall;
  end

endmodule

// ===== rtl/core/ual_ctrl.sv =====
// controller state machine: sequences memory reads, writes and scans per command
// depends on ual_pkg; drives ual_dp through dp_ctrl_t
module ual_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ual_pkg::dp_status_t  sts,
  output ual_pkg::dp_ctrl_t    ctl
);
  import ual_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_INS_WAIT = 3'd2;
  localparam logic [2:0] S_INS_PUT  = 3'd3;
  localparam logic [2:0] S_POP_WAIT = 3'd4;
  localparam logic [2:0] S_SCAN     = 3'd5;
  localparam logic [2:0] S_FILL     = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  // a new transaction may enter while the previous result moves out
  assign in_stall = !((state == S_IDLE) || ((state == S_DONE) && sts.out_free));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ctl.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          if (accept) begin
            ctl.load_item = 1'b1;
            state_next    = S_DECODE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        ctl.res_set = 1'b1;
        ctl.res_status = ST_OK;
        unique case (sts.cmd)
          CMD_APPEND: begin
            if (sts.full) begin
              ctl.res_status = ST_FULL;
            end else begin
              ctl.wr_en   = 1'b1;
              ctl.wr_sel  = WR_COUNT;
              ctl.wd_sel  = WD_VAL;
              ctl.cnt_inc = 1'b1;
            end
          end
          CMD_INSERT_AT: begin
            priority if (sts.full) begin
              ctl.res_status = ST_FULL;
            end else if (sts.pos_gt_count) begin
              ctl.res_status = ST_NOT_FOUND;
            end else if (!sts.pos_ge_count) begin
              // displaced entry is moved to the end first
              ctl.res_set = 1'b0;
              ctl.rd_en   = 1'b1;
              ctl.rd_sel  = RD_POS;
              state_next  = S_INS_WAIT;
            end else begin
              ctl.wr_en   = 1'b1;
              ctl.wr_sel  = WR_COUNT;
              ctl.wd_sel  = WD_VAL;
              ctl.cnt_inc = 1'b1;
            end
          end
          CMD_POP_LAST: begin
            if (sts.empty) begin
              ctl.res_status = ST_EMPTY;
            end else begin
              ctl.res_set = 1'b0;
              ctl.rd_en   = 1'b1;
              ctl.rd_sel  = RD_LAST;
              state_next  = S_POP_WAIT;
            end
          end
          CMD_DEL_AT: begin
            if (sts.pos_ge_count) begin
              ctl.res_status = ST_NOT_FOUND;
            end else begin
              ctl.res_set = 1'b0;
              ctl.rd_en   = 1'b1;
              ctl.rd_sel  = RD_LAST;
              state_next  = S_FILL;
            end
          end
          CMD_DEL_VALUE, CMD_SEARCH: begin
            ctl.res_set    = 1'b0;
            ctl.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
          CMD_CLEAR: begin
            ctl.cnt_clr = 1'b1;
          end
          default: begin
            ctl.res_status = ST_NOT_FOUND;
          end
        endcase
      end
      S_INS_WAIT: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = WR_COUNT;
        ctl.wd_sel = WD_RD;
        state_next = S_INS_PUT;
      end
      S_INS_PUT: begin
        ctl.wr_en      = 1'b1;
        ctl.wr_sel     = WR_POS;
        ctl.wd_sel     = WD_VAL;
        ctl.cnt_inc    = 1'b1;
        ctl.res_set    = 1'b1;
        ctl.res_status = ST_OK;
        state_next     = S_DONE;
      end
      S_POP_WAIT: begin
        ctl.cnt_dec    = 1'b1;
        ctl.res_set    = 1'b1;
        ctl.res_status = ST_OK;
        ctl.res_pop    = 1'b1;
        state_next     = S_DONE;
      end
      S_SCAN: begin
        priority if (sts.match) begin
          if (sts.cmd == CMD_SEARCH) begin
            ctl.res_set     = 1'b1;
            ctl.res_status  = ST_OK;
            ctl.res_fnd_sel = FND_CMP;
            state_next      = S_DONE;
          end else begin
            // hole at the match is filled from the last entry
            ctl.hold_load = 1'b1;
            ctl.rd_en     = 1'b1;
            ctl.rd_sel    = RD_LAST;
            state_next    = S_FILL;
          end
        end else if (!sts.cmp_valid && !sts.scan_more) begin
          ctl.res_set    = 1'b1;
          ctl.res_status = ST_NOT_FOUND;
          state_next     = S_DONE;
        end else begin
          ctl.scan_step = 1'b1;
          ctl.rd_en     = sts.scan_more;
          ctl.rd_sel    = RD_SCAN;
        end
      end
      S_FILL: begin
        ctl.wr_en      = 1'b1;
        ctl.wd_sel     = WD_RD;
        ctl.cnt_dec    = 1'b1;
        ctl.res_set    = 1'b1;
        ctl.res_status = ST_OK;
        if (sts.cmd == CMD_DEL_VALUE) begin
          ctl.wr_sel      = WR_HOLD;
          ctl.res_fnd_sel = FND_HOLD;
        end else begin
          ctl.wr_sel      = WR_POS;
          ctl.res_fnd_sel = FND_ZERO;
        end
        state_next = S_DONE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/unordered_array_list_engine.sv =====
// Unordered array list engine, top level: list of up to CAPACITY signed 32-bit
// entries kept in one single-port-write, single-port-read memory with a count.
//
// Command channel: cmd_valid / cmd_stall / cmd_item; a transaction moves when
// cmd_valid is high and cmd_stall is low. Result channel: res_valid /
// res_stall / res_item, exactly one result per command, in order.
// One command is worked on at a time. Append, clear and rejected commands
// finish in the decode state; pop last and delete at first read an entry;
// insert at (inside the list) reads the displaced entry, moves it to the end
// and then writes the value; search and delete value scan the list.
// The next command is taken in the cycle its predecessor's result is loaded.
// The scan for search and delete value reads one entry per cycle.
// Reset (rst, synchronous) empties the list and drops any pending result;
// memory contents are not cleared. If res_stall holds a finished result, the
// engine still takes the next command but keeps it waiting before its own
// result until the held one has been taken.
// depends on ual_pkg, ual_ctrl and ual_dp
module unordered_array_list_engine #(
  parameter int CAPACITY = ual_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  ual_pkg::in_item_t   cmd_item,
  output logic                res_valid,
  input  logic                res_stall,
  output ual_pkg::out_item_t  res_item
);
  import ual_pkg::*;

  dp_ctrl_t   ctl;
  dp_status_t sts;

  ual_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd_valid),
    .in_stall (cmd_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  ual_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (cmd_item),
    .ctl       (ctl),
    .sts       (sts),
    .out_stall (res_stall),
    .out_valid (res_valid),
    .out_item  (res_item)
  );

endmodule
